// File: rtl/ocvsoc_pkg.sv
// Package for the LFP OCV to state-of-charge converter.
// Holds the OCV table, field widths, the job mode codes and the job struct.
// No dependencies.
`timescale 1ns / 1ps

package ocvsoc_pkg;

   // Field widths of the two channels.
   localparam int IN_W  = 16;
   localparam int OUT_W = 15;

   // Stored table geometry.
   localparam int STORED_POINTS = 15;
   localparam int SEG_COUNT     = STORED_POINTS - 1;
   localparam int SEG_IDX_W     = $clog2(SEG_COUNT);
   localparam int PT_IDX_W      = $clog2(STORED_POINTS);
   localparam int MV_W          = 12;
   localparam int PCT_W         = 7;

   // Offset into a segment is below the widest segment span (300 mV).
   localparam int DELTA_W = 9;
   // Offset times the segment's SOC rise.
   localparam int PROD_W  = DELTA_W + PCT_W;

   // Reciprocal of each segment span, scaled by 2^RECIP_SHIFT and rounded up.
   localparam int RECIP_SHIFT = 36;
   localparam int RECIP_W     = 32;

   localparam logic [IN_W-1:0] PLATEAU_LO_MV = 16'd3250;
   localparam logic [IN_W-1:0] PLATEAU_HI_MV = 16'd3350;
   localparam logic [PCT_W-1:0] SOC_FULL_PCT = 7'd100;

   // Queue depth between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   // OCV table, ordered from high voltage to low voltage.
   localparam logic [MV_W-1:0] OCV_MV [STORED_POINTS] = '{
      12'd3650, 12'd3500, 12'd3450, 12'd3400, 12'd3370, 12'd3350,
      12'd3250, 12'd3230, 12'd3200, 12'd3150, 12'd3100, 12'd3000,
      12'd2900, 12'd2800, 12'd2500
   };
   localparam logic [PCT_W-1:0] OCV_SOC [STORED_POINTS] = '{
      7'd100, 7'd99, 7'd97, 7'd94, 7'd90, 7'd87,
      7'd22,  7'd17, 7'd12, 7'd8,  7'd5,  7'd3,
      7'd2,   7'd1,  7'd0
   };

   // What the back has to do with a classified transaction.
   typedef enum logic [1:0] {
      MODE_INTERP,
      MODE_EMPTY,
      MODE_FULL,
      MODE_PLATEAU
   } mode_type;

   typedef struct packed {
      mode_type               mode;
      logic [SEG_IDX_W-1:0]   seg_idx;
      logic [DELTA_W-1:0]     delta_mv;
   } job_type;

endpackage

// File: rtl/ocvsoc_front.sv
// Front end: accepts a cell voltage, finds its table segment and registers the job.
// Depends on ocvsoc_pkg.
`timescale 1ns / 1ps

module ocvsoc_front #(
   parameter int TABLE_POINTS = 15
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [ocvsoc_pkg::IN_W-1:0]  req_cell_mv,
   output logic                         job_valid,
   input  logic                         job_ready,
   output ocvsoc_pkg::job_type          job
);

   localparam int POINTS_RAW = (TABLE_POINTS < ocvsoc_pkg::STORED_POINTS) ?
                               TABLE_POINTS : ocvsoc_pkg::STORED_POINTS;
   localparam int POINTS     = (POINTS_RAW < 2) ? 2 : POINTS_RAW;

   localparam logic [ocvsoc_pkg::IN_W-1:0] LOW_MV =
      ocvsoc_pkg::IN_W'(ocvsoc_pkg::OCV_MV[POINTS-1]);
   localparam logic [ocvsoc_pkg::IN_W-1:0] HIGH_MV =
      ocvsoc_pkg::IN_W'(ocvsoc_pkg::OCV_MV[0]);

   logic                job_valid_ff;
   logic                job_valid_in;
   ocvsoc_pkg::job_type job_ff;
   ocvsoc_pkg::job_type job_in;
   ocvsoc_pkg::job_type class_job;
   logic                accept;

   // The holding register frees when it is empty or its job moves on.
   assign req_ready = !job_valid_ff || job_ready;
   assign accept    = req_valid && req_ready;

   // Classify the voltage. Segments are contiguous and descend, so the first
   // segment whose low end is at or below the voltage is the one that holds it.
   always_comb begin
      class_job.mode     = ocvsoc_pkg::MODE_PLATEAU;
      class_job.seg_idx  = '0;
      class_job.delta_mv = '0;
      priority if (req_cell_mv > ocvsoc_pkg::PLATEAU_LO_MV &&
                   req_cell_mv < ocvsoc_pkg::PLATEAU_HI_MV) begin
         class_job.mode = ocvsoc_pkg::MODE_PLATEAU;
      end else if (req_cell_mv <= LOW_MV) begin
         class_job.mode = ocvsoc_pkg::MODE_EMPTY;
      end else if (req_cell_mv >= HIGH_MV) begin
         class_job.mode = ocvsoc_pkg::MODE_FULL;
      end else begin
         for (int i = POINTS - 2; i >= 0; i--) begin
            if (req_cell_mv >= ocvsoc_pkg::IN_W'(ocvsoc_pkg::OCV_MV[i+1])) begin
               class_job.mode     = ocvsoc_pkg::MODE_INTERP;
               class_job.seg_idx  = ocvsoc_pkg::SEG_IDX_W'(i);
               class_job.delta_mv = ocvsoc_pkg::DELTA_W'(
                  req_cell_mv - ocvsoc_pkg::IN_W'(ocvsoc_pkg::OCV_MV[i+1]));
            end
         end
      end
   end

   // Next state of the holding register.
   always_comb begin
      job_valid_in = job_valid_ff;
      job_in       = job_ff;
      if (accept) begin
         job_valid_in = 1'b1;
         job_in       = class_job;
      end else if (job_ready) begin
         job_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   assign job_valid = job_valid_ff;
   assign job       = job_ff;

endmodule

// File: rtl/ocvsoc_queue.sv
// Short job queue between the front end and the back end.
// Depends on ocvsoc_pkg.
`timescale 1ns / 1ps

module ocvsoc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  ocvsoc_pkg::job_type push_job,
   output logic                pop_valid,
   input  logic                pop_ready,
   output ocvsoc_pkg::job_type pop_job
);

   localparam int PTR_W = $clog2(ocvsoc_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(ocvsoc_pkg::QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(ocvsoc_pkg::QUEUE_DEPTH);

   ocvsoc_pkg::job_type mem [ocvsoc_pkg::QUEUE_DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != DEPTH_CNT);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_job    = mem[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage write.
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: rtl/ocvsoc_back.sv
// Back end: two-stage interpolation pipeline that ends in the result register.
// Depends on ocvsoc_pkg.
`timescale 1ns / 1ps

module ocvsoc_back #(
   parameter int FRAC_BITS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         job_valid,
   output logic                         job_ready,
   input  ocvsoc_pkg::job_type          job,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [ocvsoc_pkg::OUT_W-1:0] rsp_soc_fixed,
   output logic                         rsp_soc_valid
);

   localparam int SOC_W  = ocvsoc_pkg::PCT_W + FRAC_BITS;
   localparam int CALC_W = (SOC_W > ocvsoc_pkg::OUT_W) ? SOC_W : ocvsoc_pkg::OUT_W;
   localparam int MUL_W  = ocvsoc_pkg::PROD_W + ocvsoc_pkg::RECIP_W;
   localparam int QSHIFT = ocvsoc_pkg::RECIP_SHIFT - FRAC_BITS;

   typedef struct packed {
      ocvsoc_pkg::mode_type               mode;
      logic [ocvsoc_pkg::SEG_IDX_W-1:0]   seg_idx;
      logic [ocvsoc_pkg::PROD_W-1:0]      prod;
   } stage_type;

   // Per-segment constants: SOC rise, span reciprocal and low-end SOC.
   logic [ocvsoc_pkg::PCT_W-1:0]   rise_tab  [ocvsoc_pkg::SEG_COUNT];
   logic [ocvsoc_pkg::RECIP_W-1:0] recip_tab [ocvsoc_pkg::SEG_COUNT];
   logic [ocvsoc_pkg::PCT_W-1:0]   base_tab  [ocvsoc_pkg::SEG_COUNT];

   for (genvar g = 0; g < ocvsoc_pkg::SEG_COUNT; g++) begin : g_seg
      localparam longint SPAN = longint'(ocvsoc_pkg::OCV_MV[g]) -
                                longint'(ocvsoc_pkg::OCV_MV[g+1]);
      localparam longint RECIP =
         ((longint'(1) << ocvsoc_pkg::RECIP_SHIFT) + SPAN - 1) / SPAN;
      assign rise_tab[g]  = ocvsoc_pkg::OCV_SOC[g] - ocvsoc_pkg::OCV_SOC[g+1];
      assign recip_tab[g] = ocvsoc_pkg::RECIP_W'(RECIP);
      assign base_tab[g]  = ocvsoc_pkg::OCV_SOC[g+1];
   end

   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   stage_type                     s1_ff;
   stage_type                     s1_in;
   logic                          s2_valid_ff;
   logic                          s2_valid_in;
   logic [ocvsoc_pkg::OUT_W-1:0]  s2_soc_ff;
   logic [ocvsoc_pkg::OUT_W-1:0]  s2_soc_in;
   logic                          s2_ok_ff;
   logic                          s2_ok_in;
   logic                          s2_load;
   logic                          s1_load;
   logic [MUL_W-1:0]              scaled;
   logic [CALC_W-1:0]             quot;
   logic [CALC_W-1:0]             base;
   logic [CALC_W-1:0]             soc_calc;

   // Stall chain: each stage loads when it is empty or its content moves on.
   assign s2_load   = !s2_valid_ff || rsp_ready;
   assign job_ready = !s1_valid_ff || s2_load;
   assign s1_load   = job_valid && job_ready;

   // Stage 1: offset times the segment's SOC rise.
   always_comb begin
      s1_in.mode    = job.mode;
      s1_in.seg_idx = job.seg_idx;
      s1_in.prod    = ocvsoc_pkg::PROD_W'(job.delta_mv * rise_tab[job.seg_idx]);
      s1_valid_in   = s1_valid_ff;
      if (s1_load) begin
         s1_valid_in = 1'b1;
      end else if (s2_load) begin
         s1_valid_in = 1'b0;
      end
   end

   // Stage 2: divide by the span through its reciprocal and add the low end, or give the empty, full or plateau result.
   always_comb begin
      scaled   = MUL_W'(s1_ff.prod) * MUL_W'(recip_tab[s1_ff.seg_idx]);
      quot     = CALC_W'(scaled >> QSHIFT);
      base     = CALC_W'(base_tab[s1_ff.seg_idx]) << FRAC_BITS;
      soc_calc = '0;
      s2_ok_in = 1'b1;
      unique case (s1_ff.mode)
         ocvsoc_pkg::MODE_INTERP: begin
            soc_calc = base + quot;
         end
         ocvsoc_pkg::MODE_EMPTY: begin
            soc_calc = '0;
         end
         ocvsoc_pkg::MODE_FULL: begin
            soc_calc = CALC_W'(ocvsoc_pkg::SOC_FULL_PCT) << FRAC_BITS;
         end
         ocvsoc_pkg::MODE_PLATEAU: begin
            s2_ok_in = 1'b0;
         end
         default: begin
            s2_ok_in = 1'b0;
         end
      endcase
      s2_soc_in   = soc_calc[ocvsoc_pkg::OUT_W-1:0];
      s2_valid_in = s2_valid_ff;
      if (s2_load) begin
         s2_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_ff <= s1_in;
      end
      if (s2_load && s1_valid_ff) begin
         s2_soc_ff <= s2_soc_in;
         s2_ok_ff  <= s2_ok_in;
      end
   end

   assign rsp_valid     = s2_valid_ff;
   assign rsp_soc_fixed = s2_soc_ff;
   assign rsp_soc_valid = s2_ok_ff;

endmodule

// File: rtl/lfp_ocv_to_soc_interpolator.sv
// Top level of the LFP OCV to state-of-charge converter.
// Depends on ocvsoc_pkg, ocvsoc_front, ocvsoc_queue and ocvsoc_back.
`timescale 1ns / 1ps

// Usage:
// Each transaction on the req_ channel carries one cell voltage in millivolts.
// Each one produces exactly one transaction on the rsp_ channel, in order:
// the state of charge in percent scaled by 2^FRAC_BITS, truncated, and a
// flag that is low when the voltage lies on the flat plateau between
// 3250 mV and 3350 mV, exclusive, where the estimate is unusable.
// Both channels use valid/ready; a transaction moves when both are high.
// From req acceptance to rsp_valid a transaction passes the front register,
// the two-entry job queue, then the multiply stage and the result register.
// Throughput is one transaction per cycle while rsp_ready is high; the two multipliers of the back
// end are each used once per transaction and are fully pipelined.
// When the receiver holds rsp_ready low, the back end fills, then the queue,
// then the front register, and only then does req_ready fall; input keeps
// being taken while a finished result waits.
// Synchronous reset empties every stage and the queue; no clearing pass.
module lfp_ocv_to_soc_interpolator #(
   parameter int FRAC_BITS    = 8,
   parameter int TABLE_POINTS = 15
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [ocvsoc_pkg::IN_W-1:0]  req_cell_mv,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [ocvsoc_pkg::OUT_W-1:0] rsp_soc_fixed,
   output logic                         rsp_soc_valid
);

   logic                front_valid;
   logic                front_ready;
   ocvsoc_pkg::job_type front_job;
   logic                queue_valid;
   logic                queue_ready;
   ocvsoc_pkg::job_type queue_job;

   // Classification of incoming voltages.
   ocvsoc_front #(
      .TABLE_POINTS (TABLE_POINTS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_cell_mv (req_cell_mv),
      .job_valid   (front_valid),
      .job_ready   (front_ready),
      .job         (front_job)
   );

   // Decoupling queue.
   ocvsoc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_job   (front_job),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_job    (queue_job)
   );

   // Interpolation and result register.
   ocvsoc_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (queue_valid),
      .job_ready     (queue_ready),
      .job           (queue_job),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_soc_fixed (rsp_soc_fixed),
      .rsp_soc_valid (rsp_soc_valid)
   );

endmodule

// File: tb/sv/tb_top.sv
// Testbench for the LFP open-circuit-voltage to state-of-charge converter.
// Drives cell voltages through the req_/rsp_ handshakes and checks every result.
// Depends on ocvsoc_pkg and lfp_ocv_to_soc_interpolator.
`timescale 1ns / 1ps

module tb_top;

   localparam int FRAC         = 8;
   localparam int POINTS       = 15;
   localparam int RANDOM_ITEMS = 1350;

   // Tracks the voltages taken by the converter and the state of charge each must give.
   class ocv_soc_tracker;
      localparam int unsigned STORED     = 15;
      localparam int unsigned PLATEAU_LO = 3250;
      localparam int unsigned PLATEAU_HI = 3350;

      typedef struct {
         logic [ocvsoc_pkg::IN_W-1:0]  mv;
         logic [ocvsoc_pkg::OUT_W-1:0] soc;
         logic                         usable;
      } soc_entry_type;

      soc_entry_type soc_expected_q[$];
      int unsigned   mismatches;
      int unsigned   checked;
      int unsigned   plateau_count;
      int unsigned   full_count;
      int unsigned   empty_count;

      function new();
         mismatches    = 0;
         checked       = 0;
         plateau_count = 0;
         full_count    = 0;
         empty_count   = 0;
      endfunction

      // Table voltages, ordered from high to low.
      static function int unsigned point_mv(int unsigned idx);
         case (idx)
            0:       return 3650;
            1:       return 3500;
            2:       return 3450;
            3:       return 3400;
            4:       return 3370;
            5:       return 3350;
            6:       return 3250;
            7:       return 3230;
            8:       return 3200;
            9:       return 3150;
            10:      return 3100;
            11:      return 3000;
            12:      return 2900;
            13:      return 2800;
            default: return 2500;
         endcase
      endfunction

      // Table state of charge in percent, matching point_mv.
      static function int unsigned point_pct(int unsigned idx);
         case (idx)
            0:       return 100;
            1:       return 99;
            2:       return 97;
            3:       return 94;
            4:       return 90;
            5:       return 87;
            6:       return 22;
            7:       return 17;
            8:       return 12;
            9:       return 8;
            10:      return 5;
            11:      return 3;
            12:      return 2;
            13:      return 1;
            default: return 0;
         endcase
      endfunction

      // Piecewise linear lookup with plateau, end and clamp handling.
      function soc_entry_type predict_soc(logic [ocvsoc_pkg::IN_W-1:0] mv);
         soc_entry_type     res;
         int unsigned       n;
         int unsigned       i;
         longint unsigned   full;
         longint unsigned   v_hi, v_lo, s_hi, s_lo, soc;
         bit                found;
         n = (POINTS < STORED) ? POINTS : STORED;
         if (n < 2) n = 2;
         full       = longint'(100) << FRAC;
         res.mv     = mv;
         res.soc    = '0;
         res.usable = 1'b0;
         found      = 1'b0;
         if (mv < PLATEAU_HI && mv > PLATEAU_LO) begin
            plateau_count++;
         end else if (mv <= point_mv(n - 1)) begin
            res.usable = 1'b1;
            empty_count++;
         end else if (mv >= point_mv(0)) begin
            res.soc    = full[ocvsoc_pkg::OUT_W-1:0];
            res.usable = 1'b1;
            full_count++;
         end else begin
            for (i = 0; i + 1 < n && !found; i++) begin
               v_hi = point_mv(i);
               v_lo = point_mv(i + 1);
               s_hi = point_pct(i);
               s_lo = point_pct(i + 1);
               if (mv >= v_lo && mv <= v_hi) begin
                  found = 1'b1;
                  soc   = s_lo << FRAC;
                  // Equal segment ends keep the lower state of charge.
                  if (v_hi > v_lo && s_hi >= s_lo)
                     soc = soc + (((mv - v_lo) * (s_hi - s_lo)) << FRAC) / (v_hi - v_lo);
                  if (soc > full) soc = full;
                  res.soc    = soc[ocvsoc_pkg::OUT_W-1:0];
                  res.usable = 1'b1;
               end
            end
         end
         return res;
      endfunction

      function void note_voltage(logic [ocvsoc_pkg::IN_W-1:0] mv);
         soc_expected_q.push_back(predict_soc(mv));
      endfunction

      function int unsigned pending();
         return soc_expected_q.size();
      endfunction

      // Compare one result with the oldest outstanding voltage.
      function void check_result(logic [ocvsoc_pkg::OUT_W-1:0] soc, logic usable);
         soc_entry_type want;
         if (soc_expected_q.size() == 0) begin
            $display("%0t: result with nothing outstanding: soc_fixed=%0d soc_valid=%0b",
                     $time, soc, usable);
            mismatches++;
            return;
         end
         want = soc_expected_q.pop_front();
         checked++;
         if (soc !== want.soc) begin
            $display("%0t: soc_fixed mismatch for %0d mV: expected %0d, actual %0d",
                     $time, want.mv, want.soc, soc);
            mismatches++;
         end
         if (usable !== want.usable) begin
            $display("%0t: soc_valid mismatch for %0d mV: expected %0b, actual %0b",
                     $time, want.mv, want.usable, usable);
            mismatches++;
         end
      endfunction
   endclass

   logic                         clock         = 1'b0;
   logic                         reset         = 1'b1;
   logic                         req_valid     = 1'b0;
   logic                         req_ready;
   logic [ocvsoc_pkg::IN_W-1:0]  req_cell_mv   = '0;
   logic                         rsp_valid;
   logic                         rsp_ready     = 1'b0;
   logic [ocvsoc_pkg::OUT_W-1:0] rsp_soc_fixed;
   logic                         rsp_soc_valid;

   ocv_soc_tracker tracker = new();

   lfp_ocv_to_soc_interpolator #(
      .FRAC_BITS    (FRAC),
      .TABLE_POINTS (POINTS)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cell_mv   (req_cell_mv),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_soc_fixed (rsp_soc_fixed),
      .rsp_soc_valid (rsp_soc_valid)
   );

   // Clock with a 12 ns period.
   always #6 clock = ~clock;

   // Reset held at the start of the run, then released.
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // Idle length: mostly none or short, now and then long.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Random voltage weighted toward the table range and its corner cases.
   function automatic logic [ocvsoc_pkg::IN_W-1:0] pick_voltage();
      int unsigned r;
      int          mv;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         mv = $urandom_range(2501, 3649);
      end else if (r < 60) begin
         mv = int'(ocv_soc_tracker::point_mv($urandom_range(0, 14))) + $urandom_range(0, 4) - 2;
      end else if (r < 68) begin
         mv = $urandom_range(3251, 3349);
      end else if (r < 78) begin
         case ($urandom_range(0, 3))
            0:       mv = $urandom_range(2490, 2510);
            1:       mv = $urandom_range(3640, 3660);
            2:       mv = $urandom_range(3245, 3255);
            default: mv = $urandom_range(3345, 3355);
         endcase
      end else if (r < 83) begin
         mv = $urandom_range(0, 2500);
      end else begin
         mv = $urandom_range(0, 65535);
      end
      return mv[ocvsoc_pkg::IN_W-1:0];
   endfunction

   // Record accepted voltages first, then check accepted results, on the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) tracker.note_voltage(req_cell_mv);
         if (rsp_valid && rsp_ready) tracker.check_result(rsp_soc_fixed, rsp_soc_valid);
      end
   end

   // Lower req_valid for the given idle gap; nothing is done for a zero gap.
   task automatic idle_gap(input int unsigned n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Present one voltage and hold it until the converter takes it.
   task automatic send_voltage(input logic [ocvsoc_pkg::IN_W-1:0] mv);
      req_valid   <= 1'b1;
      req_cell_mv <= mv;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop sending until every outstanding result has come back.
   task automatic wait_all_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
   endtask

   // Result side: runs of ready with random stalls, some long stall-free stretches.
   initial begin : sink
      int unsigned run;
      int unsigned stall;
      do @(posedge clock); while (reset);
      forever begin
         rsp_ready <= 1'b1;
         run = $urandom_range(1, 12);
         if ($urandom_range(0, 9) == 0) run = $urandom_range(40, 120);
         repeat (run) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // Directed corners, then random voltages, then drain and report.
   initial begin : stimulus
      logic [ocvsoc_pkg::IN_W-1:0] corner_mv [25];
      int unsigned                 idx;
      int unsigned                 gap;
      corner_mv = '{16'd0, 16'd65535, 16'd2500, 16'd2499, 16'd2501,
                    16'd3650, 16'd3651, 16'd3649, 16'd3250, 16'd3251,
                    16'd3349, 16'd3350, 16'd3249, 16'd3351, 16'd3370,
                    16'd3400, 16'd2800, 16'd3000, 16'd3230, 16'd3200,
                    16'd3500, 16'd3450, 16'd2650, 16'd32768, 16'd4095};
      do @(posedge clock); while (reset);

      foreach (corner_mv[i]) begin
         idle_gap(pick_gap());
         send_voltage(corner_mv[i]);
      end
      wait_all_results();

      for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
         // Every fourth block of a hundred runs with no sender gaps.
         gap = ((idx / 100) % 4 == 1) ? 0 : pick_gap();
         idle_gap(gap);
         send_voltage(pick_voltage());
         if (idx == RANDOM_ITEMS / 2) wait_all_results();
      end

      wait_all_results();
      repeat (10) @(posedge clock);

      $display("Checked %0d conversions: %0d on the plateau, %0d at full, %0d at empty,",
               tracker.checked, tracker.plateau_count, tracker.full_count,
               tracker.empty_count);
      $display("the rest interpolated, with random gaps and stalls on both channels.");
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #10_000_000;
      $display("Timed out with %0d results outstanding.", tracker.pending());
      $display("tb_top: FAIL");
      $finish;
   end

endmodule
